[src/bbt_pkg.sv]
// Shared types, codes and sizes of the block buffer tag table.
package bbt_pkg;

   localparam int SLOTS = 32;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [8:0] SLOT_LIMIT = 9'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [7:0] REFS_MAX = 8'hFF;

   typedef enum logic [1:0] {
      KIND_GET     = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_PIN     = 2'd2,
      KIND_UNPIN   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_READY = 2'd0,
      ST_FETCH = 2'd1,
      ST_NOBUF = 2'd2,
      ST_ERROR = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_SCAN   = 3'd1,
      S_DRAIN  = 3'd2,
      S_READ   = 3'd3,
      S_COMMIT = 3'd4
   } state_type;

   typedef struct packed {
      logic [31:0] block;
      logic [7:0]  dev;
   } tag_type;

   typedef struct packed {
      logic [31:0] rtime;
      logic        valid;
      logic [7:0]  refs;
   } meta_type;

   typedef struct packed {
      logic             clear;
      logic             sample;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      meta_type         hit_meta;
      logic             free;
      logic [IDX_W-1:0] vic_idx;
      meta_type         vic_meta;
   } scan_res_type;

endpackage

[src/bbt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module bbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bbt_scan.sv]
// Scan tracker: finds the first tag match and the oldest free slot as entries stream by.
module bbt_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  bbt_pkg::scan_ctl_type ctl,
   input  bbt_pkg::tag_type      req_tag,
   input  bbt_pkg::tag_type      ent_tag,
   input  bbt_pkg::meta_type     ent_meta,
   output bbt_pkg::scan_res_type res
);

   bbt_pkg::scan_res_type res_ff;
   bbt_pkg::scan_res_type res_in;

   always_comb begin
      res_in = res_ff;
      if (ctl.clear) begin
         res_in.hit  = 1'b0;
         res_in.free = 1'b0;
      end else if (ctl.sample) begin
         // Entries arrive in ascending order, so the first match is the lowest.
         if (!res_ff.hit && ent_tag == req_tag) begin
            res_in.hit      = 1'b1;
            res_in.hit_idx  = ctl.idx;
            res_in.hit_meta = ent_meta;
         end
         // Strict compare keeps the lowest slot on equal release times.
         if (ent_meta.refs == 8'd0 &&
             (!res_ff.free || ent_meta.rtime < res_ff.vic_meta.rtime)) begin
            res_in.free     = 1'b1;
            res_in.vic_idx  = ctl.idx;
            res_in.vic_meta = ent_meta;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.hit  <= 1'b0;
         res_ff.free <= 1'b0;
      end else begin
         res_ff.hit  <= res_in.hit;
         res_ff.free <= res_in.free;
      end
      res_ff.hit_idx  <= res_in.hit_idx;
      res_ff.hit_meta <= res_in.hit_meta;
      res_ff.vic_idx  <= res_in.vic_idx;
      res_ff.vic_meta <= res_in.vic_meta;
   end

   assign res = res_ff;

endmodule

[src/block_buffer_tag_table.sv]
// Block buffer tag table: request sequencer, tag and metadata memories, result register.
//
// Requests arrive on the req_ stream; each transfer carries one request (get, release,
// pin or unpin) and produces exactly one result transfer on the rsp_ stream.
// A get reads every slot once through the single read port of the tag and metadata
// memories, one slot per cycle, then passes through the drain state and commits.
// Release, pin and unpin read one slot and commit.
// The scan over the memories' one read port makes a get the slowest request.
// One request is worked on at a time; req_tready is high while the sequencer idles.
// A finished result sits in the output register; while the receiver stalls the next
// request is still taken and worked on up to its commit, which waits for the output
// register to empty.
// Reset clears the sequencer, the output register, the release clock and a flip-flop
// per slot that marks it written; an unwritten slot reads as all zero, so no clearing
// pass follows reset and the first request can transfer in the next cycle.
module block_buffer_tag_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // dev[7:0], block[39:8], slot[44:40], zero[47:45]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // slot_out[4:0], zero[7:5]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IW = bbt_pkg::IDX_W;

   bbt_pkg::state_type state_ff, state_in;

   bbt_pkg::kind_type  req_kind_ff;
   bbt_pkg::tag_type   req_tag_ff;
   logic [4:0]         req_slot_ff;
   logic               req_oor_ff;

   logic [IW-1:0]      cnt_ff, cnt_in;
   logic               rd_vld_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic [bbt_pkg::SLOTS-1:0] written_ff, written_in;
   logic [31:0]        rclk_ff, rclk_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [4:0]         rsp_slot_ff, rsp_slot_in;
   bbt_pkg::status_type rsp_status_ff, rsp_status_in;

   logic               req_fire;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic               commit_en;
   logic               commit_fire;
   bbt_pkg::scan_ctl_type scan_ctl;
   bbt_pkg::scan_res_type scan_res;

   bbt_pkg::tag_type   tag_rd, ent_tag, wr_tag;
   bbt_pkg::meta_type  meta_rd, ent_meta, wr_meta;
   logic               upd;
   logic               rel_bump;
   logic [IW-1:0]      wr_addr;
   logic               mem_wr;
   bbt_pkg::status_type res_status;
   logic [4:0]         res_slot;

   assign req_fire    = req_tvalid && req_tready;
   assign req_tready  = (state_ff == bbt_pkg::S_IDLE);
   assign commit_fire = commit_en && (!rsp_tvalid_ff || rsp_tready);
   assign mem_wr      = commit_fire && upd;

   // Entries never written since reset read as zero.
   assign ent_tag  = written_ff[rd_idx_ff] ? tag_rd  : '0;
   assign ent_meta = written_ff[rd_idx_ff] ? meta_rd : '0;

   bbt_ram #(
      .WIDTH ($bits(bbt_pkg::tag_type)),
      .DEPTH (bbt_pkg::SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_tag),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   bbt_ram #(
      .WIDTH ($bits(bbt_pkg::meta_type)),
      .DEPTH (bbt_pkg::SLOTS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_meta),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (meta_rd)
   );

   bbt_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .req_tag  (req_tag_ff),
      .ent_tag  (ent_tag),
      .ent_meta (ent_meta),
      .res      (scan_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bbt_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = (bbt_pkg::kind_type'(req_tuser) == bbt_pkg::KIND_GET) ?
                          bbt_pkg::S_SCAN : bbt_pkg::S_READ;
            end
         end
         bbt_pkg::S_SCAN: begin
            if (cnt_ff == bbt_pkg::LAST_IDX) begin
               state_in = bbt_pkg::S_DRAIN;
            end
         end
         bbt_pkg::S_DRAIN:  state_in = bbt_pkg::S_COMMIT;
         bbt_pkg::S_READ:   state_in = bbt_pkg::S_COMMIT;
         bbt_pkg::S_COMMIT: begin
            if (commit_fire) begin
               state_in = bbt_pkg::S_IDLE;
            end
         end
         default: state_in = bbt_pkg::S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      rd_en          = 1'b0;
      rd_addr        = cnt_ff;
      commit_en      = 1'b0;
      cnt_in         = '0;
      scan_ctl.clear = 1'b0;
      scan_ctl.sample = rd_vld_ff && (req_kind_ff == bbt_pkg::KIND_GET);
      scan_ctl.idx   = rd_idx_ff;
      case (state_ff)
         bbt_pkg::S_IDLE: begin
            scan_ctl.clear  = 1'b1;
            scan_ctl.sample = 1'b0;
         end
         bbt_pkg::S_SCAN: begin
            rd_en  = 1'b1;
            rd_addr = cnt_ff;
            cnt_in = IW'(cnt_ff + 1'b1);
         end
         bbt_pkg::S_DRAIN: begin
         end
         bbt_pkg::S_READ: begin
            rd_en   = 1'b1;
            rd_addr = IW'(req_slot_ff);
         end
         bbt_pkg::S_COMMIT: begin
            commit_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Read-modify-write of the selected slot.
   always_comb begin
      upd        = 1'b0;
      rel_bump   = 1'b0;
      wr_addr    = rd_idx_ff;
      wr_tag     = ent_tag;
      wr_meta    = ent_meta;
      res_status = bbt_pkg::ST_READY;
      res_slot   = req_slot_ff;
      if (req_kind_ff == bbt_pkg::KIND_GET) begin
         if (scan_res.hit) begin
            res_slot = 5'(scan_res.hit_idx);
            if (scan_res.hit_meta.refs == bbt_pkg::REFS_MAX) begin
               res_status = bbt_pkg::ST_ERROR;
            end else begin
               upd           = 1'b1;
               wr_addr       = scan_res.hit_idx;
               wr_tag        = req_tag_ff;
               wr_meta       = scan_res.hit_meta;
               wr_meta.refs  = 8'(scan_res.hit_meta.refs + 8'd1);
               wr_meta.valid = 1'b1;
               res_status    = scan_res.hit_meta.valid ? bbt_pkg::ST_READY :
                                                         bbt_pkg::ST_FETCH;
            end
         end else if (scan_res.free) begin
            // A retagged slot always reports a fetch; its valid flag is set at once, so later gets report ready.
            upd           = 1'b1;
            wr_addr       = scan_res.vic_idx;
            wr_tag        = req_tag_ff;
            wr_meta       = scan_res.vic_meta;
            wr_meta.refs  = 8'd1;
            wr_meta.valid = 1'b1;
            res_slot      = 5'(scan_res.vic_idx);
            res_status    = bbt_pkg::ST_FETCH;
         end else begin
            res_slot   = 5'd0;
            res_status = bbt_pkg::ST_NOBUF;
         end
      end else if (req_oor_ff) begin
         res_status = bbt_pkg::ST_ERROR;
      end else begin
         case (req_kind_ff)
            bbt_pkg::KIND_PIN: begin
               if (ent_meta.refs == bbt_pkg::REFS_MAX) begin
                  res_status = bbt_pkg::ST_ERROR;
               end else begin
                  upd          = 1'b1;
                  wr_meta.refs = 8'(ent_meta.refs + 8'd1);
               end
            end
            bbt_pkg::KIND_RELEASE, bbt_pkg::KIND_UNPIN: begin
               if (ent_meta.refs == 8'd0) begin
                  res_status = bbt_pkg::ST_ERROR;
               end else begin
                  upd          = 1'b1;
                  wr_meta.refs = 8'(ent_meta.refs - 8'd1);
                  if (req_kind_ff == bbt_pkg::KIND_RELEASE) begin
                     rel_bump      = 1'b1;
                     wr_meta.rtime = 32'(rclk_ff + 32'd1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      written_in = written_ff;
      if (mem_wr) begin
         written_in[wr_addr] = 1'b1;
      end
      rclk_in = (commit_fire && rel_bump) ? 32'(rclk_ff + 32'd1) : rclk_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (commit_fire) begin
         rsp_tvalid_in = 1'b1;
         rsp_slot_in   = res_slot;
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bbt_pkg::S_IDLE;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         written_ff    <= '0;
         rclk_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_en;
         written_ff    <= written_in;
         rclk_ff       <= rclk_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
      end
      if (req_fire) begin
         req_kind_ff <= bbt_pkg::kind_type'(req_tuser);
         req_tag_ff  <= '{block: req_tdata[39:8], dev: req_tdata[7:0]};
         req_slot_ff <= req_tdata[44:40];
         req_oor_ff  <= ({4'b0000, req_tdata[44:40]} >= bbt_pkg::SLOT_LIMIT);
      end
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   // A commit only happens into an empty or draining output register.
   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      commit_fire |=> rsp_tvalid_ff)
      else $error("commit did not load the result register");

   // The scan reaches the drain cycle only after issuing the last slot.
   a_scan_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbt_pkg::S_DRAIN) |-> ($past(cnt_ff) == bbt_pkg::LAST_IDX))
      else $error("scan ended before the last slot");

   // Every memory write marks its slot as written.
   a_written_mark: assert property (@(posedge clock) disable iff (reset)
      mem_wr |=> written_ff[$past(wr_addr)])
      else $error("written flag not set after a memory write");

   // No-buffer results always carry slot zero.
   a_nobuf_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_status_ff == bbt_pkg::ST_NOBUF) |-> (rsp_slot_ff == 5'd0))
      else $error("no-buffer result with nonzero slot");

endmodule

[tb/tag_table_tb_pkg.sv]
// Scoreboard for the block buffer tag table: a slot-level model of the cache and a result check.
package tag_table_tb_pkg;

   typedef struct {
      logic [4:0]          slot_out;
      bbt_pkg::status_type status;
   } grant_type;

   class tag_table_scoreboard;
      grant_type   pending_grants[$];
      logic [7:0]  tag_dev[bbt_pkg::SLOTS];
      logic [31:0] tag_block[bbt_pkg::SLOTS];
      logic [7:0]  ref_count[bbt_pkg::SLOTS];
      bit          contents_valid[bbt_pkg::SLOTS];
      logic [31:0] released_at[bbt_pkg::SLOTS];
      logic [31:0] release_ticks;
      int unsigned errors;
      int unsigned requests_seen;
      int unsigned fetches;
      int unsigned no_buffers;
      int unsigned ref_errors;

      function new();
         for (int i = 0; i < bbt_pkg::SLOTS; i++) begin
            tag_dev[i] = '0;
            tag_block[i] = '0;
            ref_count[i] = '0;
            contents_valid[i] = 1'b0;
            released_at[i] = '0;
         end
         release_ticks = '0;
         errors = 0;
         requests_seen = 0;
         fetches = 0;
         no_buffers = 0;
         ref_errors = 0;
      endfunction

      // Lowest slot holding the tag, valid or not; -1 when none does.
      function int find_tag(logic [7:0] d, logic [31:0] b);
         for (int i = 0; i < bbt_pkg::SLOTS; i++) begin
            if (tag_dev[i] == d && tag_block[i] == b) return i;
         end
         return -1;
      endfunction

      // The fetch is taken as done as soon as it is reported.
      function bbt_pkg::status_type mark_fetched(int i);
         if (contents_valid[i]) return bbt_pkg::ST_READY;
         contents_valid[i] = 1'b1;
         return bbt_pkg::ST_FETCH;
      endfunction

      function void note_request(bbt_pkg::kind_type k, logic [7:0] d, logic [31:0] b,
                                 logic [4:0] s);
         grant_type g;
         int        hit;
         int        victim;
         requests_seen++;
         g.slot_out = s;
         g.status = bbt_pkg::ST_READY;
         if (k == bbt_pkg::KIND_GET) begin
            hit = find_tag(d, b);
            if (hit >= 0) begin
               g.slot_out = 5'(hit);
               if (ref_count[hit] == bbt_pkg::REFS_MAX) begin
                  g.status = bbt_pkg::ST_ERROR;
               end else begin
                  ref_count[hit]++;
                  g.status = mark_fetched(hit);
               end
            end else begin
               // Victim is the free slot released longest ago, lowest index on a tie.
               victim = -1;
               for (int i = 0; i < bbt_pkg::SLOTS; i++) begin
                  if (ref_count[i] == 0 &&
                      (victim < 0 || released_at[i] < released_at[victim])) victim = i;
               end
               if (victim < 0) begin
                  g.slot_out = '0;
                  g.status = bbt_pkg::ST_NOBUF;
               end else begin
                  tag_dev[victim] = d;
                  tag_block[victim] = b;
                  contents_valid[victim] = 1'b0;
                  ref_count[victim] = 8'd1;
                  g.slot_out = 5'(victim);
                  g.status = mark_fetched(victim);
               end
            end
         end else if (int'(s) >= bbt_pkg::SLOTS) begin
            g.status = bbt_pkg::ST_ERROR;
         end else if (k == bbt_pkg::KIND_PIN) begin
            if (ref_count[s] == bbt_pkg::REFS_MAX) g.status = bbt_pkg::ST_ERROR;
            else ref_count[s]++;
         end else if (ref_count[s] == 0) begin
            g.status = bbt_pkg::ST_ERROR;
         end else begin
            ref_count[s]--;
            if (k == bbt_pkg::KIND_RELEASE) begin
               release_ticks++;
               released_at[s] = release_ticks;
            end
         end
         case (g.status)
            bbt_pkg::ST_FETCH: fetches++;
            bbt_pkg::ST_NOBUF: no_buffers++;
            bbt_pkg::ST_ERROR: ref_errors++;
            default: ;
         endcase
         pending_grants.push_back(g);
      endfunction

      function void check_result(logic [4:0] slot_out, bbt_pkg::status_type status);
         grant_type g;
         if (pending_grants.size() == 0) begin
            $error("result with none pending: slot_out %0d status %s", slot_out, status.name());
            errors++;
            return;
         end
         g = pending_grants.pop_front();
         if (slot_out !== g.slot_out) begin
            $error("slot_out: expected %0d, actual %0d", g.slot_out, slot_out);
            errors++;
         end
         if (status !== g.status) begin
            $error("status: expected %s, actual %s", g.status.name(), status.name());
            errors++;
         end
      endfunction
   endclass

endpackage

[tb/tb.sv]
// Top-level testbench of the block buffer tag table: stimulus, handshakes and watchdog.
module tb;

   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 550;
   localparam int SETTLE_CYCLES = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // dev[7:0], block[39:8], slot[44:40], zero[47:45]
   logic [1:0]  req_tuser = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // slot_out[4:0], zero[7:5]
   logic [1:0]  rsp_tuser;        // status[1:0]

   tag_table_tb_pkg::tag_table_scoreboard sb = new();
   bit quiet = 1'b0;
   int stall_cycles = 0;

   block_buffer_tag_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: checks every result transfer and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata[4:0], bbt_pkg::status_type'(rsp_tuser));
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send(bbt_pkg::kind_type k, logic [7:0] d, logic [31:0] b, logic [4:0] s);
      while (!quiet && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, s, b, d};
      req_tuser <= k;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(k, d, b, s);
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_grants.size() != 0);
   endtask

   // Mostly a slot that holds references, so releases and unpins do real work.
   function automatic logic [4:0] pick_slot();
      logic [4:0] s;
      s = 5'($urandom_range(31));
      if ($urandom_range(99) < 75) begin
         for (int t = 0; t < 8 && sb.ref_count[s] == 0; t++) s = 5'($urandom_range(31));
      end
      return s;
   endfunction

   initial begin
      int                r;
      int                held;
      bbt_pkg::kind_type k;
      logic [7:0]        d;
      logic [31:0]       b;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every slot holds tag 0/0 after reset, so the first get of it hits slot 0.
      send(bbt_pkg::KIND_GET, 8'h00, 32'h0000_0000, 5'd0);
      send(bbt_pkg::KIND_GET, 8'h00, 32'h0000_0000, 5'd0);
      send(bbt_pkg::KIND_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
      send(bbt_pkg::KIND_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
      send(bbt_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd0);
      send(bbt_pkg::KIND_UNPIN, 8'h00, 32'h0, 5'd0);
      send(bbt_pkg::KIND_UNPIN, 8'h00, 32'h0, 5'd0);
      send(bbt_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd0);
      send(bbt_pkg::KIND_PIN, 8'h00, 32'h0, 5'd31);
      send(bbt_pkg::KIND_UNPIN, 8'h00, 32'h0, 5'd31);
      send(bbt_pkg::KIND_PIN, 8'h00, 32'h0, 5'd2);
      send(bbt_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd2);
      send(bbt_pkg::KIND_GET, 8'h01, 32'h0000_0001, 5'd0);
      send(bbt_pkg::KIND_GET, 8'h00, 32'h0000_0000, 5'd0);
      send(bbt_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd1);
      send(bbt_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'd1);
      send(bbt_pkg::KIND_UNPIN, 8'h00, 32'h0, 5'd1);
      send(bbt_pkg::KIND_GET, 8'h80, 32'h8000_0000, 5'd31);
      send(bbt_pkg::KIND_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
      send(bbt_pkg::KIND_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31);
      drain_results();

      // Take every slot, then ask once more with no buffer left.
      for (int i = 0; i < 64; i++) begin
         held = 0;
         for (int j = 0; j < bbt_pkg::SLOTS; j++) if (sb.ref_count[j] != 0) held++;
         if (held == bbt_pkg::SLOTS) break;
         send(bbt_pkg::KIND_GET, 8'h7E, 32'(i), 5'd0);
      end
      send(bbt_pkg::KIND_GET, 8'h7E, 32'h0000_1000, 5'd0);
      for (int i = bbt_pkg::SLOTS - 1; i >= 0; i--) begin
         send(bbt_pkg::KIND_RELEASE, 8'h00, 32'h0, 5'(i));
      end

      // Saturate one slot's count, then pin and get past the top.
      // The random requests that follow may release or unpin the slot again.
      send(bbt_pkg::KIND_GET, 8'hA5, 32'h5A5A_A5A5, 5'd0);
      held = sb.find_tag(8'hA5, 32'h5A5A_A5A5);
      while (sb.ref_count[held] != bbt_pkg::REFS_MAX) begin
         send(bbt_pkg::KIND_PIN, 8'h00, 32'h0, 5'(held));
      end
      send(bbt_pkg::KIND_PIN, 8'h00, 32'h0, 5'(held));
      send(bbt_pkg::KIND_GET, 8'hA5, 32'h5A5A_A5A5, 5'd0);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 200 && n < 350);
         r = $urandom_range(99);
         if (r < 40) k = bbt_pkg::KIND_GET;
         else if (r < 70) k = bbt_pkg::KIND_RELEASE;
         else if (r < 80) k = bbt_pkg::KIND_PIN;
         else k = bbt_pkg::KIND_UNPIN;
         // A small pool of tags keeps hits frequent; the rest spans every bit.
         d = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
         b = ($urandom_range(99) < 85) ? 32'($urandom_range(15)) : 32'($urandom);
         send(k, d, b, pick_slot());
         if (n % 150 == 149) drain_results();
      end
      quiet = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d requests checked, %0d fetches, %0d without a free buffer,",
               sb.requests_seen, sb.fetches, sb.no_buffers);
      $display("summary: %0d reference errors, including count saturation and empty slots",
               sb.ref_errors);
      if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
src/bbt_pkg.sv
src/bbt_ram.sv
src/bbt_scan.sv
src/block_buffer_tag_table.sv
tb/tag_table_tb_pkg.sv
tb/tb.sv
